// File: src/ibmf_pkg.sv
package ibmf_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FracW = 24;
  localparam int unsigned ExpW  = 7;

  typedef logic [WordW-1:0] word_t;

  // Reverse the four bytes of a word.
  function automatic word_t swap_bytes(input word_t w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// File: src/ibmf_core.sv
module ibmf_core (
  input  ibmf_pkg::word_t w_i,
  output ibmf_pkg::word_t ieee_o
);
  import ibmf_pkg::*;

  logic            sign;
  logic [ExpW-1:0] hexexp;
  logic [FracW-1:0] frac;
  logic [4:0]      msb;
  logic [4:0]      lz;
  logic [23:0]     mant;
  logic signed [10:0] biased;
  logic [4:0]      sh;
  logic [23:0]     q;
  logic [26:0]     rem;
  logic [26:0]     half;
  logic [24:0]     qr;

  assign sign   = w_i[31];
  assign hexexp = w_i[30:24];
  assign frac   = w_i[23:0];

  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < FracW; i++) begin
      if (frac[i]) msb = 5'(i);
    end
  end

  assign lz     = 5'd23 - msb;
  assign mant   = frac << lz;
  assign biased = $signed({2'b00, hexexp, 2'b00}) - 11'sd153 + $signed({6'd0, msb});

  always_comb begin
    if (biased < -11'sd25) sh = 5'd26;
    else sh = 5'(11'sd1 - biased);
  end

  // keep the rounding terms wide enough for shifts past the mantissa
  assign q    = mant >> sh;
  assign half = 27'd1 << (sh - 5'd1);
  assign rem  = {3'd0, mant} & ((27'd1 << sh) - 27'd1);
  assign qr   = {1'b0, q} + {24'd0, (rem > half) || (rem == half && q[0])};

  always_comb begin
    if (frac == '0) ieee_o = '0;
    else if (biased >= 11'sd255) ieee_o = {sign, 8'hff, 23'd0};
    else if (biased >= 11'sd1) ieee_o = {sign, biased[7:0], mant[22:0]};
    else ieee_o = {sign, 7'd0, qr[23:0]};
  end

endmodule

// File: src/ibm_float_to_ieee_single.sv
// Channel  | handshake                  | payload
// input    | raw_word_valid_i/ready_o   | raw_word_i
// output   | ieee_word_valid_o/ready_i  | ieee_word_o
// config   | byte_swap_we_i             | byte_swap_i
// Path: input register, conversion logic, result register. One word
// per cycle while the output is taken. Reset clears valids and
// byte_swap. A stalled output holds its word; a new word enters when
// the input or result register is empty or the result is taken.
module ibm_float_to_ieee_single (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_swap_we_i,
  input  logic            byte_swap_i,
  input  logic            raw_word_valid_i,
  output logic            raw_word_ready_o,
  input  ibmf_pkg::word_t raw_word_i,
  output logic            ieee_word_valid_o,
  input  logic            ieee_word_ready_i,
  output ibmf_pkg::word_t ieee_word_o
);
  import ibmf_pkg::*;

  logic  swap_q;
  logic  in_vld_q;
  word_t in_q;
  logic  out_vld_q;
  word_t out_q;
  word_t conv;
  logic  adv;

  assign adv = !out_vld_q || ieee_word_ready_i;
  assign raw_word_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q    <= 1'b0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (byte_swap_we_i) swap_q <= byte_swap_i;
      if (raw_word_ready_o) in_vld_q <= raw_word_valid_i;
      if (adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_word_valid_i && raw_word_ready_o)
      in_q <= swap_q ? swap_bytes(raw_word_i) : raw_word_i;
    if (adv && in_vld_q) out_q <= conv;
  end

  ibmf_core u_core (.w_i(in_q), .ieee_o(conv));

  assign ieee_word_valid_o = out_vld_q;
  assign ieee_word_o       = out_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !ieee_word_ready_i |=> out_vld_q && $stable(out_q))
    else $error("result dropped under stall");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && adv |=> out_vld_q)
    else $error("word lost between stages");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> raw_word_ready_o)
    else $error("empty stage not ready");
`endif

endmodule

// File: sim/ibm_float_to_ieee_single_test.sv
module ibm_float_to_ieee_single_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ibmf_pkg::*;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  byte_swap_we_i = 1'b0;
  logic  byte_swap_i = 1'b0;
  logic  raw_word_valid_i = 1'b0;
  logic  raw_word_ready_o;
  word_t raw_word_i = '0;
  logic  ieee_word_valid_o;
  logic  ieee_word_ready_i = 1'b0;
  word_t ieee_word_o;

  ibm_float_to_ieee_single uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .byte_swap_we_i   (byte_swap_we_i),
    .byte_swap_i      (byte_swap_i),
    .raw_word_valid_i (raw_word_valid_i),
    .raw_word_ready_o (raw_word_ready_o),
    .raw_word_i       (raw_word_i),
    .ieee_word_valid_o(ieee_word_valid_o),
    .ieee_word_ready_i(ieee_word_ready_i),
    .ieee_word_o      (ieee_word_o)
  );

  always #4 clk_i = ~clk_i;

  word_t       pending_words[$];
  word_t       expected_ieee[$];
  logic        swap_setting = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned fail_count = 0;

  function automatic word_t ibm_to_ieee(input word_t raw, input logic swap);
    word_t       w;
    logic [23:0] frac;
    logic [23:0] mant;
    int          msb;
    int          biased;
    int          sh;
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half;
    w = swap ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
    frac = w[23:0];
    if (frac == 24'd0) return 32'h0;
    msb = 23;
    while (!frac[msb]) msb--;
    mant = frac << (23 - msb);
    biased = 4 * int'(w[30:24]) - 280 + msb + 127;
    if (biased >= 255) return {w[31], 31'h7f800000};
    if (biased >= 1) return {w[31], biased[7:0], mant[22:0]};
    sh = 1 - biased;
    if (sh > 26) sh = 26;
    q = {8'd0, mant} >> sh;
    rem = {8'd0, mant} & ((32'd1 << sh) - 1);
    half = 32'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    return {w[31], 31'd0} | q;
  endfunction

  // driver: hold valid and word until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!raw_word_valid_i || raw_word_ready_o) begin
        if (raw_word_valid_i)
          expected_ieee.push_back(ibm_to_ieee(raw_word_i, swap_setting));
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          raw_word_i <= pending_words.pop_front();
          raw_word_valid_i <= 1'b1;
        end else begin
          raw_word_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni) begin
      if (ieee_word_valid_o && ieee_word_ready_i) begin
        if (expected_ieee.size() == 0) begin
          $error("ieee_word: unexpected word %h", ieee_word_o);
          fail_count++;
        end else begin
          want = expected_ieee.pop_front();
          if (ieee_word_o !== want) begin
            $error("ieee_word: expected %h actual %h", want, ieee_word_o);
            fail_count++;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        ieee_word_ready_i <= 1'b0;
      end else begin
        ieee_word_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic word_t random_ibm();
    word_t w;
    w = $urandom();
    case ($urandom_range(5))
      0: w[30:24] = 7'(64 + $urandom_range(12) - 6);
      1: w[30:24] = 7'($urandom_range(35));
      2: w[30:24] = 7'(96 + $urandom_range(31));
      3: w[23:0] = w[23:0] >> $urandom_range(23);
      4: w[23:0] = $urandom_range(1) ? 24'd0 : 24'd1 << $urandom_range(23);
      default: ;
    endcase
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || raw_word_valid_i || expected_ieee.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_swap(input logic value);
    @(posedge clk_i);
    byte_swap_we_i <= 1'b1;
    byte_swap_i <= value;
    swap_setting = value;
    @(posedge clk_i);
    byte_swap_we_i <= 1'b0;
  endtask

  initial begin
    word_t directed[$];
    word_t w;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    directed = '{32'h0, 32'h80000000, 32'hff000000, 32'h41100000, 32'hc2640000,
                 32'h7fffffff, 32'hffffffff, 32'h60100000, 32'h61100000, 32'h00000001,
                 32'h00ffffff, 32'h21800000, 32'h22100000, 32'h1f800000, 32'ha0800001,
                 32'h21180000, 32'h20000003, 32'h40000001, 32'h3f0fffff, 32'h5f000001};
    foreach (directed[i]) pending_words.push_back(directed[i]);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      write_swap(ph[0]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      if (ph == 4) hold_off_cycles = 60;
      for (int i = 0; i < 240; i++) begin
        w = random_ibm();
        if (ph[0]) w = {w[7:0], w[15:8], w[23:16], w[31:24]};
        pending_words.push_back(w);
      end
      drain();
    end
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
